// File: sv/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
// Holds the command and status structs between controller and datapath.
// No dependencies.
package bba_pkg;

  localparam int unsigned OUT_USED_W = 21;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_TOO_LARGE = 3'd1;
  localparam logic [2:0] STS_POOL_FULL = 3'd2;
  localparam logic [2:0] STS_NO_FREE   = 3'd3;
  localparam logic [2:0] STS_NOT_ALLOC = 3'd4;
  localparam logic [2:0] STS_BAD_ADDR  = 3'd5;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_SWEEP,
    CMD_LOAD,
    CMD_WANT_STEP,
    CMD_LVL_UP,
    CMD_OFF_CLR,
    CMD_OFF_INC,
    CMD_MAP_RD,
    CMD_MAP_WR,
    CMD_SPLIT_DN,
    CMD_LOB_RD,
    CMD_LOB_CLR,
    CMD_CLIMB,
    CMD_MERGE_UP,
    CMD_DONE
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_OFF,
    TGT_BUDDY,
    TGT_NEXT
  } tgt_e;

  typedef struct packed {
    cmd_e       op;
    tgt_e       tgt;
    logic       val;
    logic [2:0] code;
  } bba_cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_fits;
    logic lev_top;
    logic pool_over;
    logic lev_nz;
    logic map_bit;
    logic off_last;
    logic lev_eq_want;
    logic bad_addr;
    logic lob_bad;
    logic buddy_free;
    logic out_free;
  } bba_sts_t;

endpackage

// File: sv/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | op_i, request_size_i, block_address_i
//  out     | output    | out_valid_o / out_stall_i | status_o, result_address_o, used_bytes_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_base_address_i
//
// One request is processed at a time. From acceptance to a valid result an allocate
// steps the size, searches the levels, probes map entries and splits blocks; a free
// climbs to its level and merges buddies; the controller returns to idle before the next acceptance.
// Each free-map update is a read followed by a write of the same map RAM entry.
// After reset a clearing pass over every map entry fills both RAMs before the first
// request is accepted; configuration is always taken.
// A finished result waits in the output register while the next request is accepted.
module buddy_block_allocator #(
  parameter int unsigned LEAF_COUNT     = 1024,
  parameter int unsigned MIN_BLOCK_LOG2 = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [31:0]                    request_size_i,
  input  logic [31:0]                    block_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [31:0]                    result_address_o,
  output logic [bba_pkg::OUT_USED_W-1:0] used_bytes_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [31:0]                    cfg_base_address_i
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .LEAF_COUNT     (LEAF_COUNT),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (op_i),
    .request_size_i     (request_size_i),
    .block_address_i    (block_address_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_base_address_i (cfg_base_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .result_address_o   (result_address_o),
    .used_bytes_o       (used_bytes_o)
  );

endmodule

// File: sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bba_ctrl.sv
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DISPATCH, S_WANT, S_POOL, S_LVL, S_SCAN_RD, S_SCAN_CHK,
    S_SPLIT, S_S_RD0, S_S_WR0, S_S_RD1, S_S_WR1, S_F_CHK, S_F_LOB, S_F_CLIMB,
    S_F_SET_RD, S_F_SET_WR, S_F_BUD_RD, S_F_BUD_CHK, S_F_CLR_RD, S_F_CLR_WR,
    S_F_CLRB_RD, S_F_CLRB_WR, S_F_UP, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    cmd_o.op   = CMD_NOP;
    cmd_o.tgt  = TGT_OFF;
    cmd_o.val  = 1'b0;
    cmd_o.code = code_q;
    case (state_q)
      S_SWEEP: begin
        cmd_o.op = CMD_SWEEP;
        if (sts_i.lev_top && sts_i.off_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = sts_i.op_free ? S_F_CHK : S_WANT;
      end
      S_WANT: begin
        if (sts_i.size_fits) begin
          state_d = S_POOL;
        end else if (sts_i.lev_top) begin
          code_d  = STS_TOO_LARGE;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_WANT_STEP;
        end
      end
      S_POOL: begin
        if (sts_i.pool_over) begin
          code_d  = STS_POOL_FULL;
          state_d = S_FIN;
        end else begin
          state_d = S_LVL;
        end
      end
      S_LVL: begin
        if (sts_i.lev_nz) begin
          cmd_o.op = CMD_OFF_CLR;
          state_d  = S_SCAN_RD;
        end else if (sts_i.lev_top) begin
          code_d  = STS_NO_FREE;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_LVL_UP;
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = CMD_MAP_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.map_bit) begin
          cmd_o.op  = CMD_MAP_WR;
          cmd_o.val = 1'b0;
          state_d   = S_SPLIT;
        end else if (!sts_i.off_last) begin
          cmd_o.op = CMD_OFF_INC;
          state_d  = S_SCAN_RD;
        end else if (sts_i.lev_top) begin
          code_d  = STS_NO_FREE;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_LVL_UP;
          state_d  = S_LVL;
        end
      end
      S_SPLIT: begin
        if (sts_i.lev_eq_want) begin
          code_d  = STS_OK;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_SPLIT_DN;
          state_d  = S_S_RD0;
        end
      end
      S_S_RD0: begin
        cmd_o.op = CMD_MAP_RD;
        state_d  = S_S_WR0;
      end
      S_S_WR0: begin
        cmd_o.op = CMD_MAP_WR;
        state_d  = S_S_RD1;
      end
      S_S_RD1: begin
        cmd_o.op  = CMD_MAP_RD;
        cmd_o.tgt = TGT_NEXT;
        state_d   = S_S_WR1;
      end
      S_S_WR1: begin
        cmd_o.op  = CMD_MAP_WR;
        cmd_o.tgt = TGT_NEXT;
        cmd_o.val = 1'b1;
        state_d   = S_SPLIT;
      end
      S_F_CHK: begin
        if (sts_i.bad_addr) begin
          code_d  = STS_BAD_ADDR;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_LOB_RD;
          state_d  = S_F_LOB;
        end
      end
      S_F_LOB: begin
        if (sts_i.lob_bad) begin
          code_d  = STS_NOT_ALLOC;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_LOB_CLR;
          state_d  = S_F_CLIMB;
        end
      end
      S_F_CLIMB: begin
        if (sts_i.lev_eq_want) begin
          state_d = S_F_SET_RD;
        end else begin
          cmd_o.op = CMD_CLIMB;
        end
      end
      S_F_SET_RD: begin
        cmd_o.op = CMD_MAP_RD;
        state_d  = S_F_SET_WR;
      end
      S_F_SET_WR: begin
        cmd_o.op  = CMD_MAP_WR;
        cmd_o.val = 1'b1;
        state_d   = S_F_BUD_RD;
      end
      S_F_BUD_RD: begin
        cmd_o.op  = CMD_MAP_RD;
        cmd_o.tgt = TGT_BUDDY;
        state_d   = S_F_BUD_CHK;
      end
      S_F_BUD_CHK: begin
        if (sts_i.buddy_free) begin
          state_d = S_F_CLR_RD;
        end else begin
          code_d  = STS_OK;
          state_d = S_FIN;
        end
      end
      S_F_CLR_RD: begin
        cmd_o.op = CMD_MAP_RD;
        state_d  = S_F_CLR_WR;
      end
      S_F_CLR_WR: begin
        cmd_o.op = CMD_MAP_WR;
        state_d  = S_F_CLRB_RD;
      end
      S_F_CLRB_RD: begin
        cmd_o.op  = CMD_MAP_RD;
        cmd_o.tgt = TGT_BUDDY;
        state_d   = S_F_CLRB_WR;
      end
      S_F_CLRB_WR: begin
        cmd_o.op  = CMD_MAP_WR;
        cmd_o.tgt = TGT_BUDDY;
        state_d   = S_F_UP;
      end
      S_F_UP: begin
        if (sts_i.lev_top) begin
          code_d  = STS_OK;
          state_d = S_FIN;
        end else begin
          cmd_o.op = CMD_MERGE_UP;
          state_d  = S_F_SET_RD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = CMD_DONE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      code_q  <= STS_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: sv/bba_datapath.sv
// Datapath of the buddy block allocator: registers, free counts and both RAMs.
// Depends on bba_pkg and bba_ram.
module bba_datapath #(
  parameter int unsigned LEAF_COUNT     = 1024,
  parameter int unsigned MIN_BLOCK_LOG2 = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bba_pkg::bba_cmd_t                 cmd_i,
  output bba_pkg::bba_sts_t                 sts_o,
  input  logic                              op_i,
  input  logic [31:0]                       request_size_i,
  input  logic [31:0]                       block_address_i,
  input  logic                              cfg_valid_i,
  input  logic [31:0]                       cfg_base_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [31:0]                       result_address_o,
  output logic [bba_pkg::OUT_USED_W-1:0]    used_bytes_o
);
  import bba_pkg::*;

  function automatic int unsigned total_entries(int unsigned n);
    int unsigned s;
    s = 0;
    for (int i = 0; i < 32; i++) begin
      s = s + (n >> i);
    end
    return s;
  endfunction

  localparam int unsigned LEVELS = $clog2(LEAF_COUNT + 1);
  localparam int unsigned LIW    = $clog2(LEVELS);
  localparam int unsigned LVW    = $clog2(LEVELS + 1);
  localparam int unsigned LW     = $clog2(LEAF_COUNT);
  localparam int unsigned CW     = $clog2(LEAF_COUNT + 1);
  localparam int unsigned TOTAL  = total_entries(LEAF_COUNT);
  localparam int unsigned MW     = $clog2(TOTAL);
  localparam longint unsigned POOL = 64'(LEAF_COUNT) << MIN_BLOCK_LOG2;
  localparam int unsigned PW     = $clog2(POOL + 1);
  localparam longint unsigned USED_MAX = (64'd1 << OUT_USED_W) - 64'd1;
  localparam logic [LVW-1:0] NO_LEVEL = {LVW{1'b1}};

  logic                  op_q;
  logic [31:0]           size_q, addr_q, base_q;
  logic [LVW-1:0]        want_q, lev_q;
  logic [MW-1:0]         start_q;
  logic [LW-1:0]         off_q, leaf_q;
  logic [PW-1:0]         blk_q, used_q;
  logic [CW-1:0]         cnt_q [LEVELS];
  logic                  out_valid_q;
  logic [2:0]            out_status_q;
  logic [31:0]           out_addr_q;
  logic [OUT_USED_W-1:0] out_used_q;

  logic [CW-1:0]         lvl_cnt, tgt_off, buddy_off, cnt_cur;
  logic                  in_range, buddy_rng, off_last, ok_done;
  logic [MW-1:0]         map_idx;
  logic [LIW-1:0]        lev_idx;
  logic [LW-1:0]         leaf_alloc;
  logic [31:0]           rel;
  logic [PW-1:0]         used_new, used_fin;
  logic                  map_we, map_wdata, map_re, map_rdata;
  logic                  lob_we, lob_re;
  logic [LW-1:0]         lob_waddr;
  logic [LVW-1:0]        lob_wdata, lob_rdata;

  assign lvl_cnt    = CW'(LEAF_COUNT >> lev_q);
  assign buddy_off  = CW'(off_q ^ LW'(1));
  assign lev_idx    = lev_q[LIW-1:0];
  assign cnt_cur    = cnt_q[lev_idx];
  assign leaf_alloc = LW'(off_q << want_q);
  assign rel        = addr_q - base_q;
  assign off_last   = (CW'(off_q) == lvl_cnt - CW'(1));
  assign ok_done    = (cmd_i.op == CMD_DONE) && (cmd_i.code == STS_OK);

  always_comb begin
    case (cmd_i.tgt)
      TGT_OFF:   tgt_off = CW'(off_q);
      TGT_BUDDY: tgt_off = buddy_off;
      TGT_NEXT:  tgt_off = CW'(off_q) + CW'(1);
      default:   tgt_off = CW'(off_q);
    endcase
  end

  assign in_range  = (tgt_off < lvl_cnt);
  assign buddy_rng = (buddy_off < lvl_cnt);
  assign map_idx   = start_q + MW'(tgt_off);

  assign used_new = op_q ? ((used_q >= blk_q) ? (used_q - blk_q) : '0)
                         : PW'(64'(used_q) + 64'(blk_q));
  assign used_fin = (cmd_i.code == STS_OK) ? used_new : used_q;

  assign map_we    = (cmd_i.op == CMD_SWEEP) || ((cmd_i.op == CMD_MAP_WR) && in_range);
  assign map_wdata = (cmd_i.op == CMD_SWEEP) ? (off_last & lvl_cnt[0]) : cmd_i.val;
  assign map_re    = (cmd_i.op == CMD_MAP_RD) && in_range;

  always_comb begin
    lob_we    = 1'b0;
    lob_waddr = leaf_q;
    lob_wdata = NO_LEVEL;
    case (cmd_i.op)
      CMD_SWEEP: begin
        lob_we    = (32'(map_idx) < LEAF_COUNT);
        lob_waddr = LW'(map_idx);
      end
      CMD_LOB_CLR: begin
        lob_we = 1'b1;
      end
      CMD_DONE: begin
        lob_we    = ok_done && !op_q;
        lob_waddr = leaf_alloc & LW'(LEAF_COUNT - 1);
        lob_wdata = want_q;
      end
      default: begin
        lob_we = 1'b0;
      end
    endcase
  end

  assign lob_re = (cmd_i.op == CMD_LOB_RD);

  bba_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_idx),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_idx),
    .rdata_o (map_rdata)
  );

  bba_ram #(.WIDTH(LVW), .DEPTH(LEAF_COUNT)) u_lob_ram (
    .clk_i   (clk_i),
    .we_i    (lob_we),
    .waddr_i (lob_waddr),
    .wdata_i (lob_wdata),
    .re_i    (lob_re),
    .raddr_i (LW'(rel >> MIN_BLOCK_LOG2)),
    .rdata_o (lob_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lev_q       <= '0;
      start_q     <= '0;
      off_q       <= '0;
      used_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
        cnt_q[j] <= CW'((LEAF_COUNT >> j) & 1);
      end
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_base_address_i;
      end
      if (out_valid_q && !out_stall_i && (cmd_i.op != CMD_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        CMD_SWEEP: begin
          if (off_last) begin
            lev_q   <= lev_q + LVW'(1);
            start_q <= start_q + MW'(lvl_cnt);
            off_q   <= '0;
          end else begin
            off_q <= off_q + LW'(1);
          end
        end
        CMD_LOAD: begin
          lev_q   <= '0;
          start_q <= '0;
        end
        CMD_WANT_STEP, CMD_LVL_UP: begin
          lev_q   <= lev_q + LVW'(1);
          start_q <= start_q + MW'(lvl_cnt);
        end
        CMD_CLIMB, CMD_MERGE_UP: begin
          lev_q   <= lev_q + LVW'(1);
          start_q <= start_q + MW'(lvl_cnt);
          off_q   <= off_q >> 1;
        end
        CMD_SPLIT_DN: begin
          lev_q   <= lev_q - LVW'(1);
          start_q <= start_q - MW'(LEAF_COUNT >> (lev_q - LVW'(1)));
          off_q   <= off_q << 1;
        end
        CMD_OFF_CLR: begin
          off_q <= '0;
        end
        CMD_OFF_INC: begin
          off_q <= off_q + LW'(1);
        end
        CMD_LOB_CLR: begin
          off_q <= leaf_q;
        end
        CMD_MAP_WR: begin
          if (in_range && cmd_i.val && !map_rdata) begin
            cnt_q[lev_idx] <= cnt_cur + CW'(1);
          end else if (in_range && !cmd_i.val && map_rdata) begin
            cnt_q[lev_idx] <= cnt_cur - CW'(1);
          end
        end
        CMD_DONE: begin
          out_valid_q <= 1'b1;
          used_q      <= used_fin;
        end
        default: begin
          off_q <= off_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        op_q   <= op_i;
        size_q <= request_size_i;
        addr_q <= block_address_i;
        want_q <= '0;
        blk_q  <= PW'(1) << MIN_BLOCK_LOG2;
      end
      CMD_WANT_STEP: begin
        want_q <= want_q + LVW'(1);
        blk_q  <= blk_q << 1;
      end
      CMD_CLIMB: begin
        blk_q <= blk_q << 1;
      end
      CMD_LOB_RD: begin
        leaf_q <= LW'(rel >> MIN_BLOCK_LOG2);
      end
      CMD_LOB_CLR: begin
        want_q <= lob_rdata;
      end
      CMD_DONE: begin
        out_status_q <= cmd_i.code;
        out_addr_q   <= (ok_done && !op_q)
                        ? base_q + 32'(64'(leaf_alloc) << MIN_BLOCK_LOG2) : 32'd0;
        out_used_q   <= (64'(used_fin) > USED_MAX) ? {OUT_USED_W{1'b1}}
                                                    : OUT_USED_W'(used_fin);
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

  assign sts_o.op_free     = op_q;
  assign sts_o.size_fits   = (64'(size_q) <= 64'(blk_q));
  assign sts_o.lev_top     = (lev_q == LVW'(LEVELS - 1));
  assign sts_o.pool_over   = ((64'(used_q) + 64'(blk_q)) > POOL);
  assign sts_o.lev_nz      = (cnt_cur != '0);
  assign sts_o.map_bit     = map_rdata;
  assign sts_o.off_last    = off_last;
  assign sts_o.lev_eq_want = (lev_q == want_q);
  assign sts_o.bad_addr    = (addr_q < base_q) || (64'(rel) >= POOL);
  assign sts_o.lob_bad     = (lob_rdata >= LVW'(LEVELS));
  assign sts_o.buddy_free  = buddy_rng && map_rdata;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_address_o = out_addr_q;
  assign used_bytes_o     = out_used_q;

endmodule
